### rtl/core/earth_occlusion_los_check_top_macros.svh
// Assertion macros for the earth occlusion line-of-sight check.
// Every macro expects signals named clk and rst in the scope where it is used.
`ifndef EARTH_OCCLUSION_LOS_CHECK_TOP_MACROS_SVH
`define EARTH_OCCLUSION_LOS_CHECK_TOP_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define EOL_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled during reset.
`define EOL_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

// Next-cycle implication that stays live through reset.
`define EOL_ASSERT_RST_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

### rtl/core/eol_pkg.sv
// Shared constants and types for the earth occlusion line-of-sight check.
// No dependencies.
`timescale 1ns / 1ps

package eol_pkg;

  localparam int COORD_WIDTH_DEF = 24;

  localparam int ER_WIDTH  = 20;
  localparam int AM_WIDTH  = 16;
  localparam int RB_WIDTH  = ER_WIDTH + 1;   // radius plus margin
  localparam int RB2_WIDTH = 2 * RB_WIDTH;

  localparam logic [ER_WIDTH-1:0] ER_RESET = 20'd51024;
  localparam logic [AM_WIDTH-1:0] AM_RESET = 16'd64;

  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] REG_EARTH_RADIUS = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ALT_MARGIN   = 4'd1;

  localparam int OUT_TDATA_W = 8;

  // Classification of one query ahead of the final product compare.
  typedef struct packed {
    logic force_block;  // target inside blocking radius
    logic force_vis;    // zero length, or closest point off the segment
    logic diff_neg;     // sensor inside blocking radius
  } flags_t;

  // Stage load enables for the split multiplier.
  typedef struct packed {
    logic ld_pp;
    logic ld_sum;
  } mul_en_t;

endpackage

### rtl/core/earth_occlusion_los_check_top.sv
// Earth occlusion line-of-sight check, top level.
// Throughput: one sensor/target pair per cycle while the output is not stalled; seven
// register stages, with the two split 50-bit multipliers taking two of them.
// Reset (synchronous): clears all stage valid bits and loads the register defaults.
`timescale 1ns / 1ps

module earth_occlusion_los_check_top #(
  parameter int COORD_WIDTH = eol_pkg::COORD_WIDTH_DEF,
  localparam int IN_TDATA_W = ((6 * COORD_WIDTH + 7) / 8) * 8
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // sensor_x, sensor_y, sensor_z, target_x, target_y, target_z, zero pad
  input  logic [IN_TDATA_W-1:0]           s_axis_tdata,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // visible, zero pad
  output logic [eol_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [eol_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [eol_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import eol_pkg::*;

  localparam int SQ_W = 2 * COORD_WIDTH;
  localparam int BW   = 2 * COORD_WIDTH + 2;

  logic [ER_WIDTH-1:0] earth_radius;
  logic [AM_WIDTH-1:0] altitude_margin;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      earth_radius    <= ER_RESET;
      altitude_margin <= AM_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_EARTH_RADIUS: earth_radius    <= cfg_data[ER_WIDTH-1:0];
        REG_ALT_MARGIN:   altitude_margin <= cfg_data[AM_WIDTH-1:0];
        default: ;
      endcase
    end
  end

  logic                  g_valid, g_ready;
  logic [SQ_W-1:0]       g_rs2, g_rt2;
  logic [BW-1:0]         g_b;
  logic signed [BW-1:0]  g_a;
  logic [RB2_WIDTH-1:0]  g_thr2, g_er2;

  logic                  c_valid, c_ready;
  flags_t                c_flags;
  logic [SQ_W-1:0]       c_diff;
  logic [BW-1:0]         c_absa, c_b;

  logic                  visible;

  eol_geom #(.COORD_WIDTH(COORD_WIDTH)) u_geom (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (s_axis_tvalid),
    .in_ready        (s_axis_tready),
    .in_coords       (s_axis_tdata[6*COORD_WIDTH-1:0]),
    .earth_radius    (earth_radius),
    .altitude_margin (altitude_margin),
    .out_valid       (g_valid),
    .out_ready       (g_ready),
    .out_rs2         (g_rs2),
    .out_rt2         (g_rt2),
    .out_b           (g_b),
    .out_a           (g_a),
    .out_thr2        (g_thr2),
    .out_er2         (g_er2)
  );

  eol_classify #(.COORD_WIDTH(COORD_WIDTH)) u_classify (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (g_valid),
    .in_ready  (g_ready),
    .rs2       (g_rs2),
    .rt2       (g_rt2),
    .b         (g_b),
    .a         (g_a),
    .thr2      (g_thr2),
    .er2       (g_er2),
    .out_valid (c_valid),
    .out_ready (c_ready),
    .out_flags (c_flags),
    .out_diff  (c_diff),
    .out_absa  (c_absa),
    .out_b     (c_b)
  );

  eol_decide #(.COORD_WIDTH(COORD_WIDTH)) u_decide (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (c_valid),
    .in_ready  (c_ready),
    .flags     (c_flags),
    .diff      (c_diff),
    .absa      (c_absa),
    .b         (c_b),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .visible   (visible)
  );

  assign m_axis_tdata = {{(OUT_TDATA_W-1){1'b0}}, visible};

endmodule

### rtl/core/eol_geom.sv
// Geometry front end: segment vector, per-axis products, squared norms and dot product.
// Three register stages. Depends on eol_pkg.
`timescale 1ns / 1ps

module eol_geom #(
  parameter int COORD_WIDTH = 24,
  localparam int W     = COORD_WIDTH,
  localparam int SQ_W  = 2 * COORD_WIDTH,
  localparam int BW    = 2 * COORD_WIDTH + 2
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [6*W-1:0]                 in_coords,
  input  logic [eol_pkg::ER_WIDTH-1:0]   earth_radius,
  input  logic [eol_pkg::AM_WIDTH-1:0]   altitude_margin,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [SQ_W-1:0]                out_rs2,
  output logic [SQ_W-1:0]                out_rt2,
  output logic [BW-1:0]                  out_b,
  output logic signed [BW-1:0]           out_a,
  output logic [eol_pkg::RB2_WIDTH-1:0]  out_thr2,
  output logic [eol_pkg::RB2_WIDTH-1:0]  out_er2
);
  import eol_pkg::*;

  logic v1, v2, v3;
  logic rdy1, rdy2, rdy3;

  assign rdy3      = !v3 || out_ready;
  assign rdy2      = !v2 || rdy3;
  assign rdy1      = !v1 || rdy2;
  assign in_ready  = rdy1;
  assign out_valid = v3;

  // stage 1: unpack and form d = T - S
  logic signed [W-1:0] in_s [3];
  logic signed [W-1:0] in_t [3];
  logic signed [W:0]   d_next [3];
  logic signed [W-1:0] s1_s [3];
  logic signed [W-1:0] s1_t [3];
  logic signed [W:0]   s1_d [3];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      in_s[k]   = in_coords[k*W +: W];
      in_t[k]   = in_coords[(k+3)*W +: W];
      d_next[k] = (W+1)'(in_t[k]) - (W+1)'(in_s[k]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (rdy1) begin
      v1 <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1) begin
      for (int k = 0; k < 3; k++) begin
        s1_s[k] <= in_s[k];
        s1_t[k] <= in_t[k];
        s1_d[k] <= d_next[k];
      end
    end
  end

  // stage 2: one multiplier per term, plus the squared radii from the registers
  logic signed [SQ_W-1:0] ss_prod [3];
  logic signed [SQ_W-1:0] tt_prod [3];
  logic signed [BW-1:0]   dd_prod [3];
  logic signed [BW-1:0]   ds_prod [3];
  logic [RB_WIDTH-1:0]    thr;
  logic [RB2_WIDTH-1:0]   thr2_next;
  logic [RB2_WIDTH-1:0]   er2_next;

  logic [SQ_W-1:0]        s2_ss [3];
  logic [SQ_W-1:0]        s2_tt [3];
  logic [BW-1:0]          s2_dd [3];
  logic signed [BW-1:0]   s2_ds [3];
  logic [RB2_WIDTH-1:0]   s2_thr2;
  logic [RB2_WIDTH-1:0]   s2_er2;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      ss_prod[k] = s1_s[k] * s1_s[k];
      tt_prod[k] = s1_t[k] * s1_t[k];
      dd_prod[k] = s1_d[k] * s1_d[k];
      ds_prod[k] = s1_d[k] * s1_s[k];
    end
    thr       = RB_WIDTH'(earth_radius) + RB_WIDTH'(altitude_margin);
    thr2_next = RB2_WIDTH'(thr) * RB2_WIDTH'(thr);
    er2_next  = RB2_WIDTH'(earth_radius) * RB2_WIDTH'(earth_radius);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (rdy2) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy2) begin
      for (int k = 0; k < 3; k++) begin
        // squares are never negative, so the raw bits are the magnitude
        s2_ss[k] <= ss_prod[k];
        s2_tt[k] <= tt_prod[k];
        s2_dd[k] <= dd_prod[k];
        s2_ds[k] <= ds_prod[k];
      end
      s2_thr2 <= thr2_next;
      s2_er2  <= er2_next;
    end
  end

  // stage 3: three-term sums
  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (rdy3) begin
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy3) begin
      out_rs2  <= s2_ss[0] + s2_ss[1] + s2_ss[2];
      out_rt2  <= s2_tt[0] + s2_tt[1] + s2_tt[2];
      out_b    <= s2_dd[0] + s2_dd[1] + s2_dd[2];
      out_a    <= s2_ds[0] + s2_ds[1] + s2_ds[2];
      out_thr2 <= s2_thr2;
      out_er2  <= s2_er2;
    end
  end

endmodule

### rtl/core/eol_classify.sv
// Classification stage: blocking radius select, target test, segment range tests.
// One register stage. Depends on eol_pkg.
`timescale 1ns / 1ps

module eol_classify #(
  parameter int COORD_WIDTH = 24,
  localparam int SQ_W = 2 * COORD_WIDTH,
  localparam int BW   = 2 * COORD_WIDTH + 2,
  localparam int CW   = ((SQ_W > eol_pkg::RB2_WIDTH) ? SQ_W : eol_pkg::RB2_WIDTH) + 1
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [SQ_W-1:0]                rs2,
  input  logic [SQ_W-1:0]                rt2,
  input  logic [BW-1:0]                  b,
  input  logic signed [BW-1:0]           a,
  input  logic [eol_pkg::RB2_WIDTH-1:0]  thr2,
  input  logic [eol_pkg::RB2_WIDTH-1:0]  er2,
  output logic                           out_valid,
  input  logic                           out_ready,
  output eol_pkg::flags_t                out_flags,
  output logic [SQ_W-1:0]                out_diff,
  output logic [BW-1:0]                  out_absa,
  output logic [BW-1:0]                  out_b
);
  import eol_pkg::*;

  logic          v;
  logic          rdy;
  logic [CW-1:0] rs2_x, rt2_x, thr2_x, er2_x, rb2_x, diff;
  logic [BW-1:0] absa;
  flags_t        flags_next;

  assign rdy       = !v || out_ready;
  assign in_ready  = rdy;
  assign out_valid = v;

  always_comb begin
    rs2_x  = CW'(rs2);
    rt2_x  = CW'(rt2);
    thr2_x = CW'(thr2);
    er2_x  = CW'(er2);
    // sensor at or above radius plus margin sees the enlarged sphere
    rb2_x  = (rs2_x >= thr2_x) ? thr2_x : er2_x;
    // both operands stay below 2^(CW-1), so the top bit is the sign
    diff   = rs2_x - rb2_x;
    absa   = BW'(-a);
    flags_next.force_block = (rt2_x < rb2_x);
    flags_next.force_vis   = (b == '0) || (!a[BW-1] && (a != '0)) || (absa > b);
    flags_next.diff_neg    = diff[CW-1];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= 1'b0;
    end else if (rdy) begin
      v <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy) begin
      out_flags <= flags_next;
      out_diff  <= diff[SQ_W-1:0];
      out_absa  <= absa;
      out_b     <= b;
    end
  end

endmodule

### rtl/core/eol_wide_mul.sv
// Two-stage unsigned multiplier: four half-width partial products, then their sum.
// Depends on eol_pkg for the stage enable type.
`timescale 1ns / 1ps

module eol_wide_mul #(
  parameter int A_WIDTH = 50,
  parameter int B_WIDTH = 48,
  localparam int P_WIDTH = A_WIDTH + B_WIDTH
) (
  input  logic                 clk,
  input  eol_pkg::mul_en_t     en,
  input  logic [A_WIDTH-1:0]   a,
  input  logic [B_WIDTH-1:0]   b,
  output logic [P_WIDTH-1:0]   p
);
  localparam int AL = (A_WIDTH + 1) / 2;
  localparam int AH = A_WIDTH - AL;
  localparam int BL = (B_WIDTH + 1) / 2;
  localparam int BH = B_WIDTH - BL;

  logic [AL+BL-1:0] pp_ll;
  logic [AL+BH-1:0] pp_lh;
  logic [AH+BL-1:0] pp_hl;
  logic [AH+BH-1:0] pp_hh;

  always_ff @(posedge clk) begin
    if (en.ld_pp) begin
      pp_ll <= a[AL-1:0] * b[BL-1:0];
      pp_lh <= a[AL-1:0] * b[B_WIDTH-1:BL];
      pp_hl <= a[A_WIDTH-1:AL] * b[BL-1:0];
      pp_hh <= a[A_WIDTH-1:AL] * b[B_WIDTH-1:BL];
    end
  end

  always_ff @(posedge clk) begin
    if (en.ld_sum) begin
      p <= (P_WIDTH'(pp_hh) << (AL + BL)) + (P_WIDTH'(pp_hl) << AL)
         + (P_WIDTH'(pp_lh) << BL) + P_WIDTH'(pp_ll);
    end
  end

endmodule

### rtl/core/eol_decide.sv
// Final decision: B*(|S|^2 - Rb^2) against A^2, then the output register.
// Three register stages. Depends on eol_pkg and eol_wide_mul.
`timescale 1ns / 1ps

module eol_decide #(
  parameter int COORD_WIDTH = 24,
  localparam int SQ_W = 2 * COORD_WIDTH,
  localparam int BW   = 2 * COORD_WIDTH + 2,
  localparam int P1_W = BW + SQ_W,
  localparam int P2_W = 2 * BW
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  eol_pkg::flags_t  flags,
  input  logic [SQ_W-1:0]  diff,
  input  logic [BW-1:0]    absa,
  input  logic [BW-1:0]    b,
  output logic             out_valid,
  input  logic             out_ready,
  output logic             visible
);
  import eol_pkg::*;

  logic            v5, v6, v7;
  logic            rdy5, rdy6, rdy7;
  flags_t          f5, f6;
  mul_en_t         mul_en;
  logic [P1_W-1:0] lhs;
  logic [P2_W-1:0] rhs;
  logic            visible_next;

  assign rdy7      = !v7 || out_ready;
  assign rdy6      = !v6 || rdy7;
  assign rdy5      = !v5 || rdy6;
  assign in_ready  = rdy5;
  assign out_valid = v7;

  assign mul_en.ld_pp  = rdy5;
  assign mul_en.ld_sum = rdy6;

  eol_wide_mul #(.A_WIDTH(BW), .B_WIDTH(SQ_W)) u_mul_lhs (
    .clk (clk),
    .en  (mul_en),
    .a   (b),
    .b   (diff),
    .p   (lhs)
  );

  eol_wide_mul #(.A_WIDTH(BW), .B_WIDTH(BW)) u_mul_rhs (
    .clk (clk),
    .en  (mul_en),
    .a   (absa),
    .b   (absa),
    .p   (rhs)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      v5 <= 1'b0;
      v6 <= 1'b0;
      v7 <= 1'b0;
    end else begin
      if (rdy5) v5 <= in_valid;
      if (rdy6) v6 <= v5;
      if (rdy7) v7 <= v6;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy5) f5 <= flags;
    if (rdy6) f6 <= f5;
  end

  // a sensor inside the blocking radius whose closest point lies on a nonzero segment is always blocked
  always_comb begin
    visible_next = !f6.force_block
                && (f6.force_vis || (!f6.diff_neg && !(P2_W'(lhs) < rhs)));
  end

  always_ff @(posedge clk) begin
    if (rdy7) visible <= visible_next;
  end

endmodule

### rtl/core/eol_checker.sv
// Port-level checks for the earth occlusion line-of-sight check, bound to the top level.
// Depends on eol_pkg and earth_occlusion_los_check_top_macros.svh.
`timescale 1ns / 1ps
`include "earth_occlusion_los_check_top_macros.svh"

module eol_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            s_axis_tready,
  input logic                            m_axis_tvalid,
  input logic                            m_axis_tready,
  input logic [eol_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
  input logic                            cfg_ready
);
  import eol_pkg::*;

  // a stalled result keeps its value
  `EOL_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "output changed while stalled")
  // only the visible bit carries data
  `EOL_ASSERT_IMPL(a_pad_zero, m_axis_tvalid, m_axis_tdata[OUT_TDATA_W-1:1] == '0, "nonzero pad bits in output transfer")
  // reset empties the pipeline
  `EOL_ASSERT_RST_NEXT(a_rst_out, rst, !m_axis_tvalid, "output valid right after reset")
  `EOL_ASSERT_RST_NEXT(a_rst_ready, rst, s_axis_tready && cfg_ready, "not ready right after reset")

endmodule

bind earth_occlusion_los_check_top eol_checker u_eol_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .cfg_ready     (cfg_ready)
);

### tb/tb_earth_occlusion_los_check_top.sv
// Self-checking testbench for earth_occlusion_los_check_top: sensor-to-target segment
// against the occluding sphere, checked by an exact integer predictor.
// Depends on eol_pkg and the top-level RTL only.
`timescale 1ns / 1ps

module tb_earth_occlusion_los_check_top;
  import eol_pkg::*;

  localparam int CW          = COORD_WIDTH_DEF;
  localparam int IN_W        = ((6 * CW + 7) / 8) * 8;
  localparam int LATENCY     = 7;
  localparam int PHASES      = 6;
  localparam int PHASE_ITEMS = 321;
  localparam int MAXC        = (1 << (CW - 1)) - 1;
  localparam int MINC        = -(1 << (CW - 1));

  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 4'hF;
  localparam logic [ER_WIDTH-1:0]  ER_MAX     = '1;
  localparam logic [AM_WIDTH-1:0]  AM_MAX     = '1;

  typedef logic signed [CW-1:0] coord_t;
  typedef logic signed [127:0]  wide_t;
  // packed from the lowest bit up: sensor x, y, z, target x, y, z
  typedef struct packed {
    coord_t tz, ty, tx, sz, sy, sx;
  } query_t;
  typedef enum logic [1:0] {CHK_PRED, CHK_BLOCKED, CHK_VISIBLE} row_chk_t;
  typedef struct {
    logic                  is_cfg;
    logic [CFG_IDX_W-1:0]  idx;
    logic [CFG_DATA_W-1:0] data;
    query_t                q;
    row_chk_t              chk;
  } row_t;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  // sensor_x, sensor_y, sensor_z, target_x, target_y, target_z, zero pad
  logic [IN_W-1:0]        s_axis_tdata = '0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  // visible, zero pad
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_IDX_W-1:0]   cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;

  logic [ER_WIDTH-1:0] er_model = ER_RESET;
  logic [AM_WIDTH-1:0] am_model = AM_RESET;
  logic                visible_q[$];
  logic                exp_visible;
  row_t                directed_rows[$];
  int                  mismatch_count = 0;
  int                  sink_left = 0;
  int                  sink_stall;
  bit                  src_throttle = 1'b1;
  bit                  sink_throttle = 1'b1;

  always #5 clk = ~clk;

  earth_occlusion_los_check_top #(
    .COORD_WIDTH(CW)
  ) u_dut (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  function automatic wide_t widen(input coord_t v);
    return {{(128 - CW){v[CW-1]}}, v};
  endfunction

  // Exact line-of-sight decision; everything is scaled by the squared segment
  // length so neither roots nor division are needed.
  function automatic logic los_clear(input query_t q);
    wide_t s[3], t[3], d[3];
    wide_t rs2, rt2, thr, rb, rb2, len2, dot, proj, lhs, rhs;
    int    k;
    s[0] = widen(q.sx); s[1] = widen(q.sy); s[2] = widen(q.sz);
    t[0] = widen(q.tx); t[1] = widen(q.ty); t[2] = widen(q.tz);
    rs2 = 0; rt2 = 0; len2 = 0; dot = 0;
    for (k = 0; k < 3; k++) begin
      d[k] = t[k] - s[k];
      rs2  += s[k] * s[k];
      rt2  += t[k] * t[k];
      len2 += d[k] * d[k];
      dot  += d[k] * s[k];
    end
    thr = wide_t'(er_model) + wide_t'(am_model);
    rb  = (rs2 >= thr * thr) ? thr : wide_t'(er_model);
    rb2 = rb * rb;
    if (rt2 < rb2) return 1'b0;
    if (len2 == 0) return 1'b1;
    if (dot > 0) return 1'b1;        // closest point behind the sensor
    proj = -dot;
    if (proj > len2) return 1'b1;    // closest point past the target
    lhs = len2 * rs2;
    rhs = rb2 * len2 + proj * proj;
    return lhs >= rhs;
  endfunction

  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(4, 32);
  endfunction

  function automatic coord_t rand_coord(input int span);
    int r;
    r = $urandom_range(0, 99);
    if (r < 12) return coord_t'($urandom());
    if (r < 24) begin
      case ($urandom_range(0, 6))
        0: return coord_t'(MINC);
        1: return coord_t'(MAXC);
        2: return '0;
        3: return coord_t'(1);
        4: return coord_t'(-1);
        5: return coord_t'(int'(er_model) + int'(am_model));
        default: return coord_t'(-int'(er_model));
      endcase
    end
    return coord_t'(int'($urandom_range(0, 2 * span)) - span);
  endfunction

  function automatic query_t make_query();
    query_t q;
    int     thr, span, r, v;
    thr  = int'(er_model) + int'(am_model);
    span = 2 * thr + 16;
    q.sx = rand_coord(span); q.sy = rand_coord(span); q.sz = rand_coord(span);
    q.tx = rand_coord(span); q.ty = rand_coord(span); q.tz = rand_coord(span);
    r = $urandom_range(0, 99);
    if (r < 8) begin
      q.tx = q.sx; q.ty = q.sy; q.tz = q.sz;
    end else if (r < 16) begin
      // straight through the centre
      q.tx = -q.sx; q.ty = -q.sy; q.tz = -q.sz;
    end else if (r < 26) begin
      // sensor on an axis at the height threshold or just under it
      v = thr - int'($urandom_range(0, 1));
      if ($urandom_range(0, 1) != 0) v = -v;
      q.sx = '0; q.sy = '0; q.sz = '0;
      case ($urandom_range(0, 2))
        0: q.sx = coord_t'(v);
        1: q.sy = coord_t'(v);
        default: q.sz = coord_t'(v);
      endcase
    end else if (r < 36) begin
      // target on an axis right at one of the two radii
      v = ($urandom_range(0, 1) != 0) ? thr : int'(er_model);
      if ($urandom_range(0, 1) != 0) v = -v;
      q.tx = '0; q.ty = '0; q.tz = '0;
      case ($urandom_range(0, 2))
        0: q.tx = coord_t'(v);
        1: q.ty = coord_t'(v);
        default: q.tz = coord_t'(v);
      endcase
    end else if (r < 46) begin
      // target offset at right angles: closest point is the sensor itself
      q.sy = '0; q.sz = '0; q.tx = q.sx;
    end
    return q;
  endfunction

  function automatic void add_query(input int sx, sy, sz, tx, ty, tz, input row_chk_t chk);
    row_t r;
    r.is_cfg = 1'b0; r.idx = '0; r.data = '0; r.chk = chk;
    r.q.sx = coord_t'(sx); r.q.sy = coord_t'(sy); r.q.sz = coord_t'(sz);
    r.q.tx = coord_t'(tx); r.q.ty = coord_t'(ty); r.q.tz = coord_t'(tz);
    directed_rows.push_back(r);
  endfunction

  function automatic void add_cfg(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] data);
    row_t r;
    r.is_cfg = 1'b1; r.idx = idx; r.data = data; r.chk = CHK_PRED; r.q = '0;
    directed_rows.push_back(r);
  endfunction

  task automatic send_query(input query_t q, input row_chk_t chk);
    int gap;
    gap = src_throttle ? idle_len() : 0;
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= IN_W'(q);
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    if (chk == CHK_PRED) visible_q.push_back(los_clear(q));
    else visible_q.push_back(chk == CHK_VISIBLE);
  endtask

  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk); while (visible_q.size() != 0);
  endtask

  task automatic wait_idle();
    drain_results();
    repeat (LATENCY + 2) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    wait_idle();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    case (idx)
      REG_EARTH_RADIUS: er_model = val[ER_WIDTH-1:0];
      REG_ALT_MARGIN:   am_model = val[AM_WIDTH-1:0];
      default: ;
    endcase
  endtask

  // result sink: ready in bursts with random stalls when throttled
  always @(posedge clk) begin
    if (sink_left != 0) begin
      sink_left--;
    end else if (!m_axis_tready) begin
      m_axis_tready <= 1'b1;
      sink_left = $urandom_range(0, 7);
    end else if (sink_throttle) begin
      sink_stall = idle_len();
      if (sink_stall != 0) begin
        m_axis_tready <= 1'b0;
        sink_left = sink_stall - 1;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (visible_q.size() == 0) begin
        mismatch_count++;
        $display("%0t: result with none expected, got tdata %h", $time, m_axis_tdata);
      end else begin
        exp_visible = visible_q.pop_front();
        if (m_axis_tdata !== OUT_TDATA_W'(exp_visible)) begin
          mismatch_count++;
          $display("%0t: visible mismatch, expected %h got %h", $time,
                   OUT_TDATA_W'(exp_visible), m_axis_tdata);
        end
      end
    end
  end

  initial begin
    logic [CFG_DATA_W-1:0] data;
    logic [ER_WIDTH-1:0]   er_v;
    logic [AM_WIDTH-1:0]   am_v;
    int                    ph, n;

    // reset registers: radius 51024, threshold 51088
    add_query(60000, 0, 0, -60000, 0, 0, CHK_BLOCKED);
    add_query(60000, 0, 0, 0, 0, 0, CHK_BLOCKED);           // target inside
    add_query(60000, 0, 0, 60000, 0, 0, CHK_VISIBLE);       // coincident
    add_query(60000, 0, 0, 51088, 0, 0, CHK_VISIBLE);       // target on sphere
    add_query(51088, 0, 0, 51087, 0, 0, CHK_BLOCKED);       // sensor at threshold
    add_query(51087, 0, 0, 51086, 0, 0, CHK_VISIBLE);
    add_query(40000, 0, 0, 40000, 60000, 0, CHK_BLOCKED);   // closest at sensor, inside
    add_query(51024, 0, 0, 51024, 40000, 0, CHK_VISIBLE);   // closest point on sphere
    add_query(60000, 40000, 0, 60000, 0, 0, CHK_PRED);      // closest point is the target
    add_query(MAXC, MAXC, MAXC, MINC, MINC, MINC, CHK_BLOCKED);
    add_query(MINC, MINC, MINC, MINC, MINC, MINC, CHK_VISIBLE);
    add_query(0, 0, 0, MAXC, 0, 0, CHK_BLOCKED);
    add_query(MAXC, 0, 0, 0, MAXC, 0, CHK_PRED);
    add_query(MINC, MAXC, MINC, MAXC, MINC, MAXC, CHK_BLOCKED);
    add_query(0, 0, 0, 0, 0, 0, CHK_BLOCKED);
    add_query(60000, 0, 0, 0, 60000, 0, CHK_PRED);
    add_query(-1, -1, -1, 1, 1, 1, CHK_BLOCKED);
    add_cfg(REG_UNUSED, 32'h0000_0000);
    add_query(60000, 0, 0, -60000, 0, 0, CHK_PRED);
    add_cfg(REG_EARTH_RADIUS, 32'h0);
    add_cfg(REG_ALT_MARGIN, 32'h0);
    add_query(0, 0, 0, 0, 0, 0, CHK_VISIBLE);
    add_query(0, 0, 0, 5, 0, 0, CHK_VISIBLE);
    add_query(MINC, MINC, MINC, MAXC, MAXC, MAXC, CHK_PRED);
    add_cfg(REG_EARTH_RADIUS, {{(CFG_DATA_W - ER_WIDTH){1'b1}}, ER_MAX});
    add_cfg(REG_ALT_MARGIN, {{(CFG_DATA_W - AM_WIDTH){1'b1}}, AM_MAX});
    add_query(1114110, 0, 0, 1114109, 0, 0, CHK_BLOCKED);
    add_query(1114109, 0, 0, 1114108, 0, 0, CHK_VISIBLE);
    add_query(MAXC, 0, 0, 0, MAXC, 0, CHK_VISIBLE);
    add_query(MAXC, MAXC, MAXC, MAXC, MAXC, MAXC, CHK_VISIBLE);

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_rows[r]) begin
      if (directed_rows[r].is_cfg) write_reg(directed_rows[r].idx, directed_rows[r].data);
      else send_query(directed_rows[r].q, directed_rows[r].chk);
    end

    for (ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0: begin er_v = ER_RESET; am_v = AM_RESET; end
        1: begin er_v = '0; am_v = '0; end
        2: begin er_v = ER_MAX; am_v = AM_MAX; end
        3: begin
          er_v = ER_WIDTH'($urandom_range(1, 4000));
          am_v = AM_WIDTH'($urandom_range(0, 300));
        end
        4: begin er_v = ER_WIDTH'($urandom()); am_v = AM_WIDTH'($urandom()); end
        default: begin er_v = ER_WIDTH'($urandom_range(40000, 60000)); am_v = AM_MAX; end
      endcase
      data = $urandom();
      data[ER_WIDTH-1:0] = er_v;
      write_reg(REG_EARTH_RADIUS, data);
      data = $urandom();
      data[AM_WIDTH-1:0] = am_v;
      write_reg(REG_ALT_MARGIN, data);
      if (ph % 2 == 1) write_reg(REG_UNUSED, $urandom());
      for (n = 0; n < PHASE_ITEMS; n++) begin
        if (n % 64 == 0) begin
          src_throttle  = ($urandom_range(0, 3) != 0);
          sink_throttle = ($urandom_range(0, 3) != 0);
        end
        // hold off until the pipeline is empty, then restart from cold
        if (n == PHASE_ITEMS / 2 && ph % 2 == 0) drain_results();
        send_query(make_query(), CHK_PRED);
      end
    end

    wait_idle();
    if (mismatch_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("%0t: timeout, %0d results outstanding", $time, visible_q.size());
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
